@@ rtl/core/dipc_pkg.sv @@
// Package: shared constants and types of the propagate-and-check block.
package dipc_pkg;

   localparam int MaxBoxesDefault     = 16;
   localparam int SamplePointsDefault = 5;
   localparam int FracBits            = 16;

   localparam int CmdWidth  = 2;
   localparam int CsrIdxW   = 3;
   localparam int CsrDataW  = 32;
   localparam int StepCntW  = 10;
   localparam int StepTimeW = 16;
   localparam int DurW      = 26;

   localparam logic [CmdWidth-1:0] CmdClear     = 2'd0;
   localparam logic [CmdWidth-1:0] CmdAppend    = 2'd1;
   localparam logic [CmdWidth-1:0] CmdPropagate = 2'd2;
   localparam logic [CmdWidth-1:0] CmdUnused    = 2'd3;

   localparam logic [CsrIdxW-1:0] RegStepTime = 3'd0;
   localparam logic [CsrIdxW-1:0] RegMinPosX  = 3'd1;
   localparam logic [CsrIdxW-1:0] RegMaxPosX  = 3'd2;
   localparam logic [CsrIdxW-1:0] RegMinPosY  = 3'd3;
   localparam logic [CsrIdxW-1:0] RegMaxPosY  = 3'd4;
   localparam logic [CsrIdxW-1:0] RegMinSpeed = 3'd5;
   localparam logic [CsrIdxW-1:0] RegMaxSpeed = 3'd6;
   localparam logic [CsrIdxW-1:0] RegUnused   = 3'd7;

   typedef struct packed {
      logic signed [31:0] hy;
      logic signed [31:0] ly;
      logic signed [31:0] hx;
      logic signed [31:0] lx;
   } box_type;

   typedef enum logic [3:0] {
      StIdle, StDur, StDd, StMulA, StMulB, StSumP, StSumV, StRound,
      StDiff, StSample, StRead, StTest, StBounds, StOut
   } state_type;

endpackage

@@ rtl/core/double_integrator_propagate_check.sv @@
// Top level: obstacle-box table with closed-form double-integrator propagate and check.
//
// A propagate word runs a short fixed sequence of multiplies and adds after its
// acceptance, then for each sample point one set-up state and a walk through
// the stored boxes in the synchronous obstacle memory, one read issue and one
// test state per box. Clear and append words give no result. The result waits
// in an output register; the block takes the next word once the result is
// taken.
module double_integrator_propagate_check #(
   parameter int MAX_BOXES     = dipc_pkg::MaxBoxesDefault,
   parameter int SAMPLE_POINTS = dipc_pkg::SamplePointsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // command[1:0] pos_x[33:2] pos_y[65:34] vel_x[97:66] vel_y[129:98]
   // accel_x[161:130] accel_y[193:162] step_count[203:194] box_low_x[235:204]
   // box_high_x[267:236] box_low_y[299:268] box_high_y[331:300], zero pad to 336
   input  logic [335:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // new_pos_x[31:0] new_pos_y[63:32] new_vel_x[95:64] new_vel_y[127:96]
   // duration[153:128] collided[154] in_bounds[155] valid_res[156], pad to 160
   output logic [159:0] rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [dipc_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [dipc_pkg::CsrDataW-1:0] csr_data
);
   localparam int IdxW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
   localparam int CntW = $clog2(MAX_BOXES + 1);
   localparam int SpW  = $clog2(SAMPLE_POINTS + 1);
   localparam int Fb   = dipc_pkg::FracBits;
   localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_BOXES);
   localparam logic [SpW-1:0]  MaxSp  = SpW'(SAMPLE_POINTS);
   localparam logic signed [39:0] NumSp = 40'(SAMPLE_POINTS);

   // configuration registers
   logic [15:0] step_time_ff;
   logic signed [31:0] min_px_ff, max_px_ff, min_py_ff, max_py_ff, min_sp_ff, max_sp_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         step_time_ff <= 16'd655;
         min_px_ff <= -32'sd655360;  max_px_ff <= 32'sd655360;
         min_py_ff <= -32'sd655360;  max_py_ff <= 32'sd655360;
         min_sp_ff <= -32'sd65536;   max_sp_ff <= 32'sd65536;
      end else if (csr_valid) begin
         case (csr_index)
            dipc_pkg::RegStepTime: step_time_ff <= csr_data[15:0];
            dipc_pkg::RegMinPosX:  min_px_ff <= csr_data;
            dipc_pkg::RegMaxPosX:  max_px_ff <= csr_data;
            dipc_pkg::RegMinPosY:  min_py_ff <= csr_data;
            dipc_pkg::RegMaxPosY:  max_py_ff <= csr_data;
            dipc_pkg::RegMinSpeed: min_sp_ff <= csr_data;
            dipc_pkg::RegMaxSpeed: max_sp_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // input field views
   logic [1:0] f_cmd;
   logic signed [31:0] f_px, f_py, f_vx, f_vy, f_ax, f_ay;
   logic [9:0] f_sc;
   dipc_pkg::box_type f_box;
   assign f_cmd = req_tdata[1:0];
   assign f_px = req_tdata[33:2];     assign f_py = req_tdata[65:34];
   assign f_vx = req_tdata[97:66];    assign f_vy = req_tdata[129:98];
   assign f_ax = req_tdata[161:130];  assign f_ay = req_tdata[193:162];
   assign f_sc = req_tdata[203:194];
   assign f_box = {req_tdata[331:300], req_tdata[299:268], req_tdata[267:236],
                   req_tdata[235:204]};

   // obstacle memory
   dipc_pkg::box_type mem [MAX_BOXES];
   dipc_pkg::box_type rd_ff;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] bi_ff, bi_in;
   logic mem_we;
   always_ff @(posedge clock) begin
      if (mem_we) mem[count_ff[IdxW-1:0]] <= f_box;
      rd_ff <= mem[bi_ff[IdxW-1:0]];
   end

   // datapath registers
   dipc_pkg::state_type st_ff, st_in;
   logic signed [31:0] px_ff, py_ff, vx_ff, vy_ff, ax_ff, ay_ff;
   logic [25:0] d_ff;
   logic [51:0] dd_ff;
   logic signed [84:0] mvx_ff, mvy_ff, max_ff, may_ff;   // v*d, u*dd
   logic signed [58:0] mavx_ff, mavy_ff;                 // u*d
   logic signed [90:0] tpx_ff, tpy_ff;
   logic signed [59:0] tvx_ff, tvy_ff;
   logic signed [31:0] nx_ff, ny_ff, nvx_ff, nvy_ff;
   logic signed [33:0] dx_ff, dy_ff;
   logic signed [39:0] dxj_ff, dyj_ff;                   // diff * j
   logic [SpW-1:0] j_ff, j_in;
   logic coll_ff, coll_in, inb_ff;
   logic rv_ff, rv_in;

   function automatic logic signed [31:0] rsat(input logic signed [90:0] a, input int s);
      logic signed [90:0] r;
      r = (a + (91'sd1 <<< (s - 1))) >>> s;
      if (r > 91'sd2147483647) return 32'sh7fffffff;
      if (r < -91'sd2147483648) return 32'sh80000000;
      return r[31:0];
   endfunction

   // box test on the scaled offset: floor(a / N) >= m  <=>  a >= N * m
   logic signed [39:0] rel_lx, rel_hx, rel_ly, rel_hy;
   assign rel_lx = NumSp * (40'(rd_ff.lx) - 40'(px_ff) + 40'sd1);
   assign rel_hx = NumSp * (40'(rd_ff.hx) - 40'(px_ff));
   assign rel_ly = NumSp * (40'(rd_ff.ly) - 40'(py_ff) + 40'sd1);
   assign rel_hy = NumSp * (40'(rd_ff.hy) - 40'(py_ff));

   logic hit;
   assign hit = dxj_ff >= rel_lx && dxj_ff < rel_hx && dyj_ff >= rel_ly && dyj_ff < rel_hy;

   // control sequencer
   always_comb begin
      st_in = st_ff; count_in = count_ff; bi_in = bi_ff; j_in = j_ff;
      coll_in = coll_ff; rv_in = rv_ff; mem_we = 1'b0;
      req_tready = (st_ff == dipc_pkg::StIdle) && !rv_ff;
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      case (st_ff)
         dipc_pkg::StIdle: if (req_tvalid && req_tready) begin
            case (f_cmd)
               dipc_pkg::CmdClear: count_in = '0;
               dipc_pkg::CmdAppend: if (count_ff < MaxCnt) begin
                  mem_we = 1'b1; count_in = count_ff + 1'b1;
               end
               dipc_pkg::CmdPropagate: st_in = dipc_pkg::StDur;
               default: ;
            endcase
         end
         dipc_pkg::StDur:   st_in = dipc_pkg::StDd;
         dipc_pkg::StDd:    st_in = dipc_pkg::StMulA;
         dipc_pkg::StMulA:  st_in = dipc_pkg::StMulB;
         dipc_pkg::StMulB:  st_in = dipc_pkg::StSumP;
         dipc_pkg::StSumP:  st_in = dipc_pkg::StSumV;
         dipc_pkg::StSumV:  st_in = dipc_pkg::StRound;
         dipc_pkg::StRound: st_in = dipc_pkg::StDiff;
         dipc_pkg::StDiff: begin
            j_in = SpW'(1); coll_in = 1'b0; st_in = dipc_pkg::StSample;
         end
         dipc_pkg::StSample: begin
            bi_in = '0;
            st_in = (count_ff == '0) ? dipc_pkg::StBounds : dipc_pkg::StRead;
         end
         dipc_pkg::StRead: st_in = dipc_pkg::StTest;
         dipc_pkg::StTest: begin
            if (hit) coll_in = 1'b1;
            if (bi_ff + 1'b1 < count_ff) begin
               bi_in = bi_ff + 1'b1; st_in = dipc_pkg::StRead;
            end else if (j_ff < MaxSp) begin
               j_in = j_ff + 1'b1; st_in = dipc_pkg::StSample;
            end else st_in = dipc_pkg::StBounds;
         end
         dipc_pkg::StBounds: st_in = dipc_pkg::StOut;
         dipc_pkg::StOut: begin
            rv_in = 1'b1; st_in = dipc_pkg::StIdle;
         end
         default: st_in = dipc_pkg::StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= dipc_pkg::StIdle; count_ff <= '0; rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; count_ff <= count_in; rv_ff <= rv_in;
      end
      bi_ff <= bi_in; j_ff <= j_in; coll_ff <= coll_in;
   end

   // arithmetic steps: multiplies, sums, rounding and the bounds compare, one group per state
   always_ff @(posedge clock) begin
      case (st_ff)
         dipc_pkg::StIdle: if (req_tvalid && req_tready) begin
            px_ff <= f_px; py_ff <= f_py; vx_ff <= f_vx; vy_ff <= f_vy;
            ax_ff <= f_ax; ay_ff <= f_ay; d_ff <= 26'(f_sc) * 26'(step_time_ff);
         end
         dipc_pkg::StDur: dd_ff <= 52'(d_ff) * 52'(d_ff);
         dipc_pkg::StDd: begin
            mvx_ff <= 85'(vx_ff) * $signed({59'd0, d_ff});
            mvy_ff <= 85'(vy_ff) * $signed({59'd0, d_ff});
            mavx_ff <= 59'(ax_ff) * $signed({33'd0, d_ff});
            mavy_ff <= 59'(ay_ff) * $signed({33'd0, d_ff});
         end
         // u*dd in two halves of dd
         dipc_pkg::StMulA: begin
            max_ff <= 85'(ax_ff) * $signed({59'd0, dd_ff[25:0]});
            may_ff <= 85'(ay_ff) * $signed({59'd0, dd_ff[25:0]});
         end
         dipc_pkg::StMulB: begin
            max_ff <= max_ff + ((85'(ax_ff) * $signed({59'd0, dd_ff[51:26]})) <<< 26);
            may_ff <= may_ff + ((85'(ay_ff) * $signed({59'd0, dd_ff[51:26]})) <<< 26);
         end
         dipc_pkg::StSumP: begin
            tpx_ff <= (91'(px_ff) <<< (2*Fb+1)) + (91'(mvx_ff) <<< (Fb+1)) + 91'(max_ff);
            tpy_ff <= (91'(py_ff) <<< (2*Fb+1)) + (91'(mvy_ff) <<< (Fb+1)) + 91'(may_ff);
         end
         dipc_pkg::StSumV: begin
            tvx_ff <= (60'(vx_ff) <<< Fb) + 60'(mavx_ff);
            tvy_ff <= (60'(vy_ff) <<< Fb) + 60'(mavy_ff);
         end
         dipc_pkg::StRound: begin
            nx_ff <= rsat(tpx_ff, 2*Fb+1);  ny_ff <= rsat(tpy_ff, 2*Fb+1);
            nvx_ff <= rsat(91'(tvx_ff), Fb); nvy_ff <= rsat(91'(tvy_ff), Fb);
         end
         dipc_pkg::StDiff: begin
            dx_ff <= 34'(nx_ff) - 34'(px_ff);  dy_ff <= 34'(ny_ff) - 34'(py_ff);
         end
         dipc_pkg::StSample: begin
            dxj_ff <= 40'(dx_ff) * $signed(40'(j_ff));
            dyj_ff <= 40'(dy_ff) * $signed(40'(j_ff));
         end
         dipc_pkg::StBounds:
            inb_ff <= nx_ff > min_px_ff && nx_ff < max_px_ff && ny_ff > min_py_ff &&
                      ny_ff < max_py_ff && nvx_ff > min_sp_ff && nvx_ff < max_sp_ff &&
                      nvy_ff > min_sp_ff && nvy_ff < max_sp_ff;
         default: ;
      endcase
   end

   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {3'd0, inb_ff & ~coll_ff, inb_ff, coll_ff, d_ff,
                       nvy_ff, nvx_ff, ny_ff, nx_ff};

   // checks
   a_cnt: assert property (@(posedge clock) disable iff (reset) count_ff <= MaxCnt)
      else $error("box count overflow");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      st_ff != dipc_pkg::StIdle |-> !req_tready) else $error("ready while busy");
   a_bi: assert property (@(posedge clock) disable iff (reset)
      st_ff == dipc_pkg::StTest |-> bi_ff < count_ff) else $error("walk past table");
   a_out: assert property (@(posedge clock) disable iff (reset)
      st_ff == dipc_pkg::StOut |=> rsp_tvalid) else $error("result lost");
endmodule
